### rtl/ssm_pkg.sv
package ssm_pkg;

  // Request field widths
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned KEY_W   = 16;
  localparam int unsigned COUNT_W = 7;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_MEMBER = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

endpackage

### rtl/sorted_set_member_insert_delete.sv
// Sorted set: member / insert / delete on distinct values kept in ascending order.
// Each request runs an ordered walk to the lower-bound position (skipped when the set
// is empty), then a decide step; an insert that shifts then moves the larger entries up
// one slot and a delete that shifts moves them down one slot. Busy is high throughout;
// the result strobe comes in the cycle busy drops, and the next request may be taken
// then. Synchronous reset empties the set; no receiver stall.
module sorted_set_member_insert_delete #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [ssm_pkg::MODE_W-1:0]    in_mode,
  input  logic [ssm_pkg::KEY_W-1:0]     in_key_value,
  output logic                          out_valid,
  output logic                          out_success,
  output logic                          out_full_refused,
  output logic [ssm_pkg::COUNT_W-1:0]   out_entry_count
);

  import ssm_pkg::*;

  // Stored key width: only the low KW bits (VALUE_BITS, at most 16) of the 16-bit key matter.
  localparam int unsigned KW = (VALUE_BITS < KEY_W) ? VALUE_BITS : KEY_W;
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a request
  localparam logic [2:0] S_SCAN = 3'd1;  // ordered walk for lower bound
  localparam logic [2:0] S_DEC  = 3'd2;  // decide on the operation
  localparam logic [2:0] S_SHUP = 3'd3;  // move larger entries up one slot
  localparam logic [2:0] S_SHDN = 3'd4;  // move larger entries down one slot

  logic [2:0]        state_r, state_nxt;
  logic [CW-1:0]     occ_r, occ_nxt;        // entries held
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [KW-1:0]     key_r, key_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;        // scan read address
  logic [CW-1:0]     chk_r, chk_nxt;        // address of data now on rd_data
  logic              vld_r, vld_nxt;        // rd_data carries a scan read
  logic [CW-1:0]     pos_r, pos_nxt;        // lower-bound position
  logic              found_r, found_nxt;
  logic [CW-1:0]     rj_r, rj_nxt;          // shift read address
  logic              more_r, more_nxt;      // shift reads still to issue
  logic              pend_r, pend_nxt;      // shift read data to write back
  logic [CW-1:0]     pa_r, pa_nxt;          // address of pending shift data
  logic              ov_r, ov_nxt;
  logic              succ_r, succ_nxt;
  logic              refu_r, refu_nxt;

  // RAM port signals
  logic          we;
  logic [AW-1:0] waddr;
  logic [KW-1:0] wdata;
  logic [AW-1:0] raddr;
  logic [KW-1:0] rd_data;

  // Address helpers
  logic [CW-1:0] pa_up, pa_dn, occ_m1, pos_p1;

  assign pa_up  = pa_r + CW'(1);
  assign pa_dn  = pa_r - CW'(1);
  assign occ_m1 = occ_r - CW'(1);
  assign pos_p1 = pos_r + CW'(1);

  ssm_ram #(
    .WIDTH (KW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    occ_nxt   = occ_r;
    mode_nxt  = mode_r;
    key_nxt   = key_r;
    idx_nxt   = idx_r;
    chk_nxt   = chk_r;
    vld_nxt   = 1'b0;
    pos_nxt   = pos_r;
    found_nxt = found_r;
    rj_nxt    = rj_r;
    more_nxt  = more_r;
    pend_nxt  = 1'b0;
    pa_nxt    = pa_r;
    ov_nxt    = 1'b0;
    succ_nxt  = succ_r;
    refu_nxt  = refu_r;
    we        = 1'b0;
    waddr     = pa_up[AW-1:0];
    wdata     = rd_data;
    raddr     = idx_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          mode_nxt = in_mode;
          key_nxt  = in_key_value[KW-1:0];
          idx_nxt  = '0;
          if (occ_r == '0) begin
            // empty set: key would go at slot zero
            pos_nxt   = '0;
            found_nxt = 1'b0;
            state_nxt = S_DEC;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // issue next read, hold at the last live entry
        raddr   = idx_r[AW-1:0];
        chk_nxt = idx_r;
        vld_nxt = 1'b1;
        if (idx_r < occ_m1) begin
          idx_nxt = idx_r + CW'(1);
        end
        if (vld_r) begin
          // shared compare: first entry not below the key
          if (rd_data >= key_r) begin
            pos_nxt   = chk_r;
            found_nxt = (rd_data == key_r);
            vld_nxt   = 1'b0;
            state_nxt = S_DEC;
          end else if (chk_r == occ_m1) begin
            pos_nxt   = occ_r;
            found_nxt = 1'b0;
            vld_nxt   = 1'b0;
            state_nxt = S_DEC;
          end
        end
      end

      S_DEC: begin
        succ_nxt  = 1'b0;
        refu_nxt  = 1'b0;
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
        case (mode_r)
          MODE_MEMBER: begin
            succ_nxt = found_r;
          end
          MODE_INSERT: begin
            if (!found_r) begin
              if (occ_r == CW'(CAPACITY)) begin
                refu_nxt = 1'b1;
              end else if (pos_r == occ_r) begin
                // append at the top, no shift
                we       = 1'b1;
                waddr    = pos_r[AW-1:0];
                wdata    = key_r;
                occ_nxt  = occ_r + CW'(1);
                succ_nxt = 1'b1;
              end else begin
                ov_nxt    = 1'b0;
                rj_nxt    = occ_m1;
                more_nxt  = 1'b1;
                state_nxt = S_SHUP;
              end
            end
          end
          MODE_DELETE: begin
            if (found_r) begin
              if (pos_p1 == occ_r) begin
                // last entry: just drop it
                occ_nxt  = occ_m1;
                succ_nxt = 1'b1;
              end else begin
                ov_nxt    = 1'b0;
                rj_nxt    = pos_p1;
                more_nxt  = 1'b1;
                state_nxt = S_SHDN;
              end
            end
          end
          default: begin
            // unused code: no change, failure
            succ_nxt = 1'b0;
          end
        endcase
      end

      S_SHUP: begin
        // top-down: read j, write j+1 in the cycle after
        raddr = rj_r[AW-1:0];
        if (more_r) begin
          pend_nxt = 1'b1;
          pa_nxt   = rj_r;
          if (rj_r == pos_r) begin
            more_nxt = 1'b0;
          end else begin
            rj_nxt = rj_r - CW'(1);
          end
        end
        if (pend_r) begin
          we    = 1'b1;
          waddr = pa_up[AW-1:0];
          wdata = rd_data;
        end else if (!more_r) begin
          // hole is open: drop the key in
          we        = 1'b1;
          waddr     = pos_r[AW-1:0];
          wdata     = key_r;
          occ_nxt   = occ_r + CW'(1);
          succ_nxt  = 1'b1;
          refu_nxt  = 1'b0;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_SHDN: begin
        // bottom-up: read j, write j-1 in the cycle after
        raddr = rj_r[AW-1:0];
        if (more_r) begin
          pend_nxt = 1'b1;
          pa_nxt   = rj_r;
          if (rj_r == occ_m1) begin
            more_nxt = 1'b0;
          end else begin
            rj_nxt = rj_r + CW'(1);
          end
        end
        if (pend_r) begin
          we    = 1'b1;
          waddr = pa_dn[AW-1:0];
          wdata = rd_data;
        end else if (!more_r) begin
          occ_nxt   = occ_m1;
          succ_nxt  = 1'b1;
          refu_nxt  = 1'b0;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      occ_r   <= '0;
      vld_r   <= 1'b0;
      more_r  <= 1'b0;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      vld_r   <= vld_nxt;
      more_r  <= more_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    mode_r  <= mode_nxt;
    key_r   <= key_nxt;
    idx_r   <= idx_nxt;
    chk_r   <= chk_nxt;
    pos_r   <= pos_nxt;
    found_r <= found_nxt;
    rj_r    <= rj_nxt;
    pa_r    <= pa_nxt;
    succ_r  <= succ_nxt;
    refu_r  <= refu_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = ov_r;
  assign out_success      = succ_r;
  assign out_full_refused = refu_r;
  // count register updates on the same edge as the strobe
  assign out_entry_count  = COUNT_W'(occ_r);

endmodule

### rtl/ssm_ram.sv
module ssm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
